/* hw/rtl/btlpm_pkg.sv */
package btlpm_pkg;

	localparam int NODE_COUNT = 16384;
	localparam int IDX_W      = $clog2(NODE_COUNT);
	localparam int CNT_W      = $clog2(NODE_COUNT + 1);
	localparam int ADDR_W     = 32;
	localparam int LEN_W      = 6;
	localparam int HOP_W      = 8;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FULL = 1'b1;

	typedef struct packed {
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic             valid;
		logic [HOP_W-1:0] hop;
	} node_t;

	typedef struct packed {
		logic              action;
		logic [ADDR_W-1:0] address;
		logic [LEN_W-1:0]  prefix_len;
		logic [HOP_W-1:0]  next_hop;
	} req_t;

	typedef struct packed {
		logic             hit;
		logic [HOP_W-1:0] hop_out;
		logic             status;
	} rsp_t;

endpackage

/* hw/rtl/btlpm_node_ram.sv */
module btlpm_node_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/binary_trie_longest_prefix_match.sv */
// A lookup walks the trie from the root and reads one trie level per cycle from the node RAM,
// which has a single read port. An insert walks the same way and also passes through S_NEW
// for each node that it allocates.
// Throughput: one request at a time; busy is high until the result strobe is issued.
// Reset clears the root node, held in flip-flops, and sets the node count to one; the
// node RAM itself is not cleared. The receiver cannot stall, so done is a one-cycle pulse.
module binary_trie_longest_prefix_match
	import btlpm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_NEW  = 3'b100
	} state_t;

	state_t            state_q;
	logic              action_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  len_q;
	logic [HOP_W-1:0]  hop_q;
	logic [LEN_W-1:0]  depth_q;
	logic [IDX_W-1:0]  cur_q;
	logic              fresh_q;
	logic              hit_q;
	logic [HOP_W-1:0]  found_q;
	node_t             root_q;
	logic [CNT_W-1:0]  used_q;
	logic              done_q;
	rsp_t              rsp_q;

	logic                    mem_we;
	logic [IDX_W-1:0]        mem_waddr;
	node_t                   mem_wdata;
	logic [IDX_W-1:0]        mem_raddr;
	logic [$bits(node_t)-1:0] mem_rdata;

	node_t            node;
	node_t            node_upd;
	logic             bit_sel;
	logic [IDX_W-1:0] child;
	logic             full;
	logic             lk_hit;
	logic [HOP_W-1:0] lk_hop;
	logic [LEN_W-1:0] len_in;

	btlpm_node_ram #(
		.WIDTH($bits(node_t)),
		.DEPTH(NODE_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// The root lives in flip-flops; a node just allocated is known to be empty.
	always_comb begin
		if (cur_q == '0) begin
			node = root_q;
		end else if (fresh_q) begin
			node = '0;
		end else begin
			node = node_t'(mem_rdata);
		end
	end

	assign bit_sel   = addr_q[ADDR_W-1];
	assign child     = bit_sel ? node.right : node.left;
	assign full      = (used_q == CNT_W'(NODE_COUNT));
	assign mem_raddr = child;
	assign lk_hit    = node.valid | hit_q;
	assign lk_hop    = node.valid ? node.hop : found_q;
	assign len_in    = (req.prefix_len > MAX_LEN) ? MAX_LEN : req.prefix_len;

	always_comb begin
		node_upd = node;
		if (bit_sel) begin
			node_upd.right = used_q[IDX_W-1:0];
		end else begin
			node_upd.left = used_q[IDX_W-1:0];
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = '0;
		unique case (state_q)
			S_NEW: begin
				mem_we = 1'b1;
			end
			S_WALK: begin
				if (action_q == ACT_INSERT) begin
					if (depth_q == len_q) begin
						if (len_q != '0 && !node.valid) begin
							mem_we          = 1'b1;
							mem_wdata       = node;
							mem_wdata.valid = 1'b1;
							mem_wdata.hop   = hop_q;
						end
					end else if (child == '0 && !full && cur_q != '0) begin
						mem_we    = 1'b1;
						mem_wdata = node_upd;
					end
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			root_q  <= '0;
			used_q  <= CNT_W'(1);
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_WALK;
					end
				end
				S_NEW: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (action_q == ACT_INSERT) begin
						if (depth_q == len_q) begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end else if (child == '0) begin
							if (full) begin
								state_q <= S_IDLE;
								done_q  <= 1'b1;
							end else begin
								if (cur_q == '0) begin
									root_q <= node_upd;
								end
								used_q  <= used_q + CNT_W'(1);
								state_q <= S_NEW;
							end
						end
					end else if (depth_q == MAX_LEN || child == '0) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					action_q <= req.action;
					addr_q   <= req.address;
					len_q    <= len_in;
					hop_q    <= req.next_hop;
					depth_q  <= '0;
					cur_q    <= '0;
					fresh_q  <= 1'b0;
					hit_q    <= 1'b0;
					found_q  <= '0;
				end
			end
			S_NEW: begin
				fresh_q <= 1'b1;
			end
			S_WALK: begin
				hit_q   <= lk_hit;
				found_q <= lk_hop;
				if (action_q == ACT_INSERT) begin
					if (depth_q == len_q) begin
						rsp_q <= '{hit: 1'b0, hop_out: '0, status: ST_OK};
					end else if (child != '0) begin
						cur_q   <= child;
						fresh_q <= 1'b0;
						depth_q <= depth_q + LEN_W'(1);
						addr_q  <= addr_q << 1;
					end else if (full) begin
						rsp_q <= '{hit: 1'b0, hop_out: '0, status: ST_FULL};
					end else begin
						cur_q   <= used_q[IDX_W-1:0];
						depth_q <= depth_q + LEN_W'(1);
						addr_q  <= addr_q << 1;
					end
				end else if (depth_q == MAX_LEN || child == '0) begin
					rsp_q <= '{hit: lk_hit, hop_out: lk_hop, status: ST_OK};
				end else begin
					cur_q   <= child;
					fresh_q <= 1'b0;
					depth_q <= depth_q + LEN_W'(1);
					addr_q  <= addr_q << 1;
				end
			end
			default: begin
				fresh_q <= 1'b0;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

/* tb/sv/tb_binary_trie_longest_prefix_match.sv */
module tb_binary_trie_longest_prefix_match;
	import btlpm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	class route_checker;
		bit [IDX_W-1:0] left_of[NODE_COUNT];
		bit [IDX_W-1:0] right_of[NODE_COUNT];
		bit             routed[NODE_COUNT];
		bit [HOP_W-1:0] hop_at[NODE_COUNT];
		int unsigned    used;
		rsp_t           pending_rsp[$];
		int unsigned    failures;

		function new();
			left_of[0]  = '0;
			right_of[0] = '0;
			routed[0]   = 1'b0;
			hop_at[0]   = '0;
			used        = 1;
			failures    = 0;
		endfunction

		function logic add_route(logic [ADDR_W-1:0] a, logic [LEN_W-1:0] l,
				logic [HOP_W-1:0] h);
			int unsigned depth_lim;
			int unsigned cur;
			int unsigned nxt;
			logic        b;
			depth_lim = (l > MAX_LEN) ? ADDR_W : l;
			cur = 0;
			for (int i = 0; i < depth_lim; i++) begin
				b   = a[ADDR_W-1-i];
				nxt = b ? right_of[cur] : left_of[cur];
				if (nxt == 0) begin
					// The walk stops here; nodes made so far keep no route.
					if (used >= NODE_COUNT)
						return ST_FULL;
					nxt = used;
					used++;
					left_of[nxt]  = '0;
					right_of[nxt] = '0;
					routed[nxt]   = 1'b0;
					hop_at[nxt]   = '0;
					if (b)
						right_of[cur] = nxt;
					else
						left_of[cur] = nxt;
				end
				cur = nxt;
			end
			// The first route for a prefix wins.
			if (depth_lim > 0 && !routed[cur]) begin
				routed[cur] = 1'b1;
				hop_at[cur] = h;
			end
			return ST_OK;
		endfunction

		function rsp_t find_route(logic [ADDR_W-1:0] a);
			rsp_t        r;
			int unsigned cur;
			r   = '0;
			cur = 0;
			for (int d = 0; d <= ADDR_W; d++) begin
				if (routed[cur]) begin
					r.hit     = 1'b1;
					r.hop_out = hop_at[cur];
				end
				if (d == ADDR_W)
					break;
				cur = a[ADDR_W-1-d] ? right_of[cur] : left_of[cur];
				if (cur == 0)
					break;
			end
			r.status = ST_OK;
			return r;
		endfunction

		function void note_request(req_t q);
			rsp_t r;
			if (q.action == ACT_INSERT) begin
				r        = '0;
				r.status = add_route(q.address, q.prefix_len, q.next_hop);
			end else begin
				r = find_route(q.address);
			end
			pending_rsp = {pending_rsp, r};
		endfunction

		function void check_response(rsp_t got);
			rsp_t exp;
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response %h, none pending", $time, got);
				failures++;
				return;
			end
			exp = pending_rsp.pop_front();
			if (got.hit !== exp.hit) begin
				$display("%0t: hit expected %0b got %0b", $time, exp.hit, got.hit);
				failures++;
			end
			if (got.hop_out !== exp.hop_out) begin
				$display("%0t: hop_out expected %0d got %0d", $time, exp.hop_out,
					got.hop_out);
				failures++;
			end
			if (got.status !== exp.status) begin
				$display("%0t: status expected %0b got %0b", $time, exp.status,
					got.status);
				failures++;
			end
		endfunction
	endclass

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	route_checker sb = new();

	logic [ADDR_W-1:0] known_addr[$];
	logic [LEN_W-1:0]  known_len[$];
	int unsigned       idle_pct = 0;

	binary_trie_longest_prefix_match DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_response(rsp);
	end

	function automatic req_t mk(logic act, logic [ADDR_W-1:0] a, logic [LEN_W-1:0] l,
			logic [HOP_W-1:0] h);
		req_t q;
		q.action     = act;
		q.address    = a;
		q.prefix_len = l;
		q.next_hop   = h;
		return q;
	endfunction

	// Keeps the top l bits of a and fills the rest at random.
	function automatic logic [ADDR_W-1:0] under_prefix(logic [ADDR_W-1:0] a,
			logic [LEN_W-1:0] l);
		logic [ADDR_W-1:0] mask;
		mask = (l >= MAX_LEN) ? '1 : ~(32'hFFFF_FFFF >> l);
		return (a & mask) | (32'($urandom) & ~mask);
	endfunction

	function automatic void remember(logic [ADDR_W-1:0] a, logic [LEN_W-1:0] l);
		if (l == 0)
			return;
		known_addr = {known_addr, a};
		known_len  = {known_len, (l > MAX_LEN) ? MAX_LEN : l};
		if (known_addr.size() > 1024) begin
			void'(known_addr.pop_front());
			void'(known_len.pop_front());
		end
	endfunction

	function automatic req_t random_request();
		int unsigned       k;
		int unsigned       pick;
		logic [LEN_W-1:0]  l;
		logic [ADDR_W-1:0] a;
		k    = $urandom_range(99);
		pick = (known_addr.size() > 0) ? $urandom_range(known_addr.size() - 1) : 0;
		if (k < 35) begin
			k = $urandom_range(99);
			if (k < 5)
				l = '0;
			else if (k < 15)
				l = LEN_W'($urandom_range(33, 63));
			else if (k < 30)
				l = LEN_W'($urandom_range(1, 12));
			else
				l = LEN_W'($urandom_range(13, 32));
			a = 32'($urandom);
			if (known_addr.size() > 0) begin
				k = $urandom_range(99);
				if (k < 15) begin
					// A prefix no longer than a known one, along a path that already exists.
					a = known_addr[pick];
					l = LEN_W'($urandom_range(1, known_len[pick]));
				end else if (k < 60) begin
					a = under_prefix(known_addr[pick], known_len[pick]);
				end
			end
			remember(a, l);
			return mk(ACT_INSERT, a, l, HOP_W'($urandom));
		end
		if (k < 75 && known_addr.size() > 0)
			a = under_prefix(known_addr[pick], known_len[pick]);
		else
			a = 32'($urandom);
		return mk(ACT_LOOKUP, a, LEN_W'($urandom), HOP_W'($urandom));
	endfunction

	task automatic send(req_t q);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= q;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(q);
	endtask

	task automatic run_random(int unsigned n, int unsigned pct);
		idle_pct = pct;
		repeat (n)
			send(random_request());
	endtask

	initial begin
		int unsigned wait_cycles;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty trie, zero length insert and ignored lookup fields.
		send(mk(ACT_LOOKUP, 32'h0000_0000, 6'd0, 8'd0));
		send(mk(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd63, 8'hFF));
		send(mk(ACT_INSERT, 32'hC0A8_0101, 6'd0, 8'd5));
		send(mk(ACT_LOOKUP, 32'hC0A8_0101, 6'd0, 8'd0));
		// First route for a prefix is kept; longer prefix overrides shorter one.
		send(mk(ACT_INSERT, 32'h0A00_0000, 6'd8, 8'd10));
		send(mk(ACT_INSERT, 32'h0A00_0000, 6'd8, 8'd99));
		send(mk(ACT_LOOKUP, 32'h0A01_0203, 6'd8, 8'd0));
		send(mk(ACT_INSERT, 32'h0A01_0000, 6'd16, 8'hFF));
		send(mk(ACT_LOOKUP, 32'h0A01_0203, 6'd0, 8'd0));
		send(mk(ACT_LOOKUP, 32'h0A02_0304, 6'd0, 8'd0));
		// A route through nodes that exist but hold no route yet.
		send(mk(ACT_INSERT, 32'h0000_0000, 6'd4, 8'd3));
		send(mk(ACT_LOOKUP, 32'h0B00_0000, 6'd0, 8'd0));
		send(mk(ACT_INSERT, 32'h8000_0000, 6'd1, 8'd0));
		send(mk(ACT_LOOKUP, 32'h8000_0000, 6'd0, 8'd0));
		send(mk(ACT_INSERT, 32'hFFFF_FFFF, 6'd32, 8'd77));
		send(mk(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'd0));
		send(mk(ACT_LOOKUP, 32'hFFFF_FFFE, 6'd0, 8'd0));
		// Lengths above 32 behave as 32.
		send(mk(ACT_INSERT, 32'h0000_0000, 6'd33, 8'd1));
		send(mk(ACT_INSERT, 32'h0000_0001, 6'd63, 8'd2));
		send(mk(ACT_LOOKUP, 32'h0000_0000, 6'd0, 8'd0));
		send(mk(ACT_LOOKUP, 32'h0000_0001, 6'd0, 8'd0));
		send(mk(ACT_LOOKUP, 32'h0000_0002, 6'd0, 8'd0));
		remember(32'h0A01_0000, 6'd16);
		remember(32'h0000_0000, 6'd4);

		run_random(50, 0);
		run_random(50, 88);
		run_random(50, 20);

		// Fill the node store with host routes, with a random request now and then.
		idle_pct = 0;
		while (sb.used < NODE_COUNT) begin
			if ($urandom_range(7) == 0) begin
				send(random_request());
			end else begin
				req_t q;
				q = mk(ACT_INSERT, 32'($urandom), MAX_LEN, HOP_W'($urandom));
				remember(q.address, q.prefix_len);
				send(q);
			end
		end
		run_random(20, 88);
		run_random(20, 0);

		@(posedge clk);
		start <= 1'b0;
		wait_cycles = 0;
		while (sb.pending_rsp.size() > 0 && wait_cycles < 2000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (80)
			@(posedge clk);
		if (sb.pending_rsp.size() > 0) begin
			$display("%0t: %0d responses never arrived", $time, sb.pending_rsp.size());
			sb.failures++;
		end
		if (sb.failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
